@@ hw/rtl/bmt_pkg.sv @@
// Shared constants, codes and types of the breakpoint match table.
package bmt_pkg;

   localparam int MaxEntries = 64;
   localparam int PosW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
   localparam int CntW       = $clog2(MaxEntries + 1);

   localparam int ActionW = 3;
   localparam int AddrW   = 16;
   localparam int KindW   = 3;
   localparam int IndexW  = 6;
   localparam int StatusW = 2;
   localparam int HitW    = 6;
   localparam int UsedW   = 7;
   localparam int CmpW    = (PosW > IndexW) ? PosW : IndexW;

   // action codes
   localparam logic [ActionW-1:0] ACT_ADD       = 3'd0;
   localparam logic [ActionW-1:0] ACT_DEL_ADDR  = 3'd1;
   localparam logic [ActionW-1:0] ACT_DEL_INDEX = 3'd2;
   localparam logic [ActionW-1:0] ACT_CHECK     = 3'd3;
   localparam logic [ActionW-1:0] ACT_PURGE     = 3'd4;

   localparam logic [KindW-1:0] KIND_EXEC = 3'd0;

   typedef enum logic [StatusW-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2,
      STAT_DUP  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SWEEP,
      S_DROP,
      S_COMPACT,
      S_RESP
   } state_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_APPEND,
      OP_KILL_ADDR,
      OP_KILL_INDEX,
      OP_CLEAR_MARK,
      OP_ROTATE,
      OP_KILL_MARKED,
      OP_COMPACT
   } cell_op_type;

   typedef struct packed {
      logic             valid;
      logic             mark;
      logic             perm;
      logic [KindW-1:0] kind;
      logic [AddrW-1:0] addr;
   } entry_type;

   typedef struct packed {
      logic [AddrW-1:0]  addr;
      logic [KindW-1:0]  kind;
      logic              perm;
      logic [IndexW-1:0] index;
   } key_type;

   typedef struct packed {
      cell_op_type op;
      logic        phase;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic dup;
      logic hit_any;
      logic hit_temp;
      logic addr_any;
      logic idx_any;
      logic swap_any;
   } summary_type;

endpackage

@@ hw/rtl/bmt_cell.sv @@
// One table slot: holds an entry, compares it and trades it with its neighbors.
module bmt_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [bmt_pkg::PosW-1:0] pos,
   input  bmt_pkg::cmd_type         cmd,
   input  bmt_pkg::key_type         key,
   input  bmt_pkg::entry_type       probe,
   input  bmt_pkg::entry_type       dn_in,
   input  bmt_pkg::entry_type       up_in,
   input  logic                     seen_in,
   output bmt_pkg::entry_type       state_out,
   output logic                     seen_out,
   output logic                     first_hit,
   output logic                     left_swap,
   output logic                     addr_hit,
   output logic                     index_hit,
   output logic                     key_hit,
   output logic                     tail
);

   bmt_pkg::entry_type ent_ff, ent_in;
   logic is_first, is_last, up_valid, dn_valid, is_left, right_swap, rot_mark;

   assign is_first = (pos == '0);
   assign is_last  = (pos == bmt_pkg::PosW'(bmt_pkg::MaxEntries - 1));
   assign up_valid = up_in.valid & ~is_last;
   assign dn_valid = dn_in.valid | is_first;

   assign addr_hit  = ent_ff.valid & (ent_ff.addr == key.addr);
   assign key_hit   = addr_hit & (ent_ff.kind == key.kind);
   assign index_hit = ent_ff.valid &
                      (bmt_pkg::CmpW'(pos) == bmt_pkg::CmpW'(key.index));
   assign first_hit = key_hit & ~seen_in;
   assign seen_out  = seen_in | key_hit;
   assign tail      = ent_ff.valid & ~up_valid;

   // odd-even pairing: the left cell of a pair pulls from above
   assign is_left    = (pos[0] == cmd.phase);
   assign left_swap  = is_left & ~ent_ff.valid & up_valid;
   assign right_swap = ~is_left & ent_ff.valid & ~dn_valid;

   // entry arriving from above is marked if it shares the probe's temp address
   assign rot_mark = up_in.valid & probe.valid & ~probe.perm & (up_in.addr == probe.addr);

   assign state_out = ent_ff;

   always_comb begin
      ent_in = ent_ff;
      unique case (cmd.op)
         bmt_pkg::OP_APPEND: begin
            if (~ent_ff.valid & dn_valid) begin
               ent_in.valid = 1'b1;
               ent_in.mark  = 1'b0;
               ent_in.perm  = key.perm;
               ent_in.kind  = key.kind;
               ent_in.addr  = key.addr;
            end
         end
         bmt_pkg::OP_KILL_ADDR: begin
            if (addr_hit) ent_in.valid = 1'b0;
         end
         bmt_pkg::OP_KILL_INDEX: begin
            if (index_hit) ent_in.valid = 1'b0;
         end
         bmt_pkg::OP_CLEAR_MARK: begin
            ent_in.mark = 1'b0;
         end
         bmt_pkg::OP_ROTATE: begin
            ent_in      = up_in;
            ent_in.mark = up_in.mark | rot_mark;
         end
         bmt_pkg::OP_KILL_MARKED: begin
            if (ent_ff.mark) begin
               ent_in.valid = 1'b0;
               ent_in.mark  = 1'b0;
            end
         end
         bmt_pkg::OP_COMPACT: begin
            if (left_swap) begin
               ent_in = up_in;
            end else if (right_swap) begin
               ent_in.valid = 1'b0;
            end
         end
         default: begin
            ent_in = ent_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
         ent_ff.mark  <= 1'b0;
      end else begin
         ent_ff <= ent_in;
      end
   end

endmodule

@@ hw/rtl/bmt_ctrl.sv @@
// Sequencer: latches a request, drives the cell row and forms the response.
module bmt_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [bmt_pkg::ActionW-1:0]     req_action,
   input  logic [bmt_pkg::AddrW-1:0]       req_address,
   input  logic [bmt_pkg::KindW-1:0]       req_access_kind,
   input  logic                            req_permanent,
   input  logic [bmt_pkg::IndexW-1:0]      req_entry_index,
   input  bmt_pkg::summary_type            summary,
   input  logic [bmt_pkg::PosW-1:0]        hit_pos,
   output logic                            busy,
   output bmt_pkg::key_type                key,
   output bmt_pkg::cmd_type                cmd,
   output logic                            rsp_strobe,
   output bmt_pkg::status_type             status,
   output logic [bmt_pkg::PosW-1:0]        pos
);

   bmt_pkg::state_type  state_ff, state_in;
   bmt_pkg::key_type    key_ff, key_in;
   logic [bmt_pkg::ActionW-1:0] action_ff, action_in;
   bmt_pkg::status_type status_ff, status_in;
   logic [bmt_pkg::PosW-1:0] pos_ff, pos_in;
   logic [bmt_pkg::PosW-1:0] sweep_ff, sweep_in;
   logic phase_ff, phase_in;
   logic last_swap_ff, last_swap_in;
   logic accept, sweep_done;

   assign accept     = start & (state_ff == bmt_pkg::S_IDLE);
   assign sweep_done = (sweep_ff == bmt_pkg::PosW'(bmt_pkg::MaxEntries - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmt_pkg::S_IDLE: begin
            if (accept) state_in = bmt_pkg::S_EXEC;
         end
         bmt_pkg::S_EXEC: begin
            unique case (action_ff)
               bmt_pkg::ACT_DEL_ADDR:
                  state_in = summary.addr_any ? bmt_pkg::S_COMPACT : bmt_pkg::S_RESP;
               bmt_pkg::ACT_DEL_INDEX:
                  state_in = summary.idx_any ? bmt_pkg::S_COMPACT : bmt_pkg::S_RESP;
               bmt_pkg::ACT_CHECK:
                  state_in = summary.hit_temp ? bmt_pkg::S_COMPACT : bmt_pkg::S_RESP;
               bmt_pkg::ACT_PURGE:
                  state_in = bmt_pkg::S_SWEEP;
               default:
                  state_in = bmt_pkg::S_RESP;
            endcase
         end
         bmt_pkg::S_SWEEP: begin
            if (sweep_done) state_in = bmt_pkg::S_DROP;
         end
         bmt_pkg::S_DROP: begin
            state_in = bmt_pkg::S_COMPACT;
         end
         bmt_pkg::S_COMPACT: begin
            // two quiet phases in a row: the row is in order
            if (~summary.swap_any & ~last_swap_ff) state_in = bmt_pkg::S_RESP;
         end
         bmt_pkg::S_RESP: begin
            state_in = bmt_pkg::S_IDLE;
         end
         default: begin
            state_in = bmt_pkg::S_IDLE;
         end
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      key_in       = key_ff;
      action_in    = action_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      sweep_in     = '0;
      phase_in     = 1'b0;
      last_swap_in = 1'b1;
      cmd.op       = bmt_pkg::OP_NOP;
      cmd.phase    = phase_ff;
      unique case (state_ff)
         bmt_pkg::S_IDLE: begin
            if (accept) begin
               key_in.addr  = req_address;
               key_in.kind  = req_access_kind;
               key_in.perm  = req_permanent;
               key_in.index = req_entry_index;
               action_in    = req_action;
            end
         end
         bmt_pkg::S_EXEC: begin
            status_in = bmt_pkg::STAT_MISS;
            pos_in    = '0;
            unique case (action_ff)
               bmt_pkg::ACT_ADD: begin
                  if (summary.full) begin
                     status_in = bmt_pkg::STAT_FULL;
                  end else if (summary.dup) begin
                     status_in = bmt_pkg::STAT_DUP;
                  end else begin
                     status_in = bmt_pkg::STAT_OK;
                     cmd.op    = bmt_pkg::OP_APPEND;
                  end
               end
               bmt_pkg::ACT_DEL_ADDR: begin
                  if (summary.addr_any) begin
                     status_in = bmt_pkg::STAT_OK;
                     cmd.op    = bmt_pkg::OP_KILL_ADDR;
                  end
               end
               bmt_pkg::ACT_DEL_INDEX: begin
                  if (summary.idx_any) begin
                     status_in = bmt_pkg::STAT_OK;
                     cmd.op    = bmt_pkg::OP_KILL_INDEX;
                  end
               end
               bmt_pkg::ACT_CHECK: begin
                  if (summary.hit_any) begin
                     status_in = bmt_pkg::STAT_OK;
                     pos_in    = hit_pos;
                     if (summary.hit_temp) cmd.op = bmt_pkg::OP_KILL_ADDR;
                  end
               end
               bmt_pkg::ACT_PURGE: begin
                  status_in = bmt_pkg::STAT_OK;
                  cmd.op    = bmt_pkg::OP_CLEAR_MARK;
               end
               default: begin
                  status_in = bmt_pkg::STAT_MISS;
               end
            endcase
         end
         bmt_pkg::S_SWEEP: begin
            cmd.op   = bmt_pkg::OP_ROTATE;
            sweep_in = sweep_ff + 1'b1;
         end
         bmt_pkg::S_DROP: begin
            cmd.op = bmt_pkg::OP_KILL_MARKED;
         end
         bmt_pkg::S_COMPACT: begin
            cmd.op       = bmt_pkg::OP_COMPACT;
            phase_in     = ~phase_ff;
            last_swap_in = summary.swap_any;
         end
         bmt_pkg::S_RESP: begin
            cmd.op = bmt_pkg::OP_NOP;
         end
         default: begin
            cmd.op = bmt_pkg::OP_NOP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmt_pkg::S_IDLE;
         sweep_ff     <= '0;
         phase_ff     <= 1'b0;
         last_swap_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         phase_ff     <= phase_in;
         last_swap_ff <= last_swap_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      action_ff <= action_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
   end

   assign busy       = (state_ff != bmt_pkg::S_IDLE);
   assign key        = key_ff;
   assign rsp_strobe = (state_ff == bmt_pkg::S_RESP);
   assign status     = status_ff;
   assign pos        = pos_ff;

endmodule

@@ hw/rtl/breakpoint_match_table.sv @@
// Top level of the breakpoint match table: cell row, sequencer and response ports.
//
//   channel   | ports                                              | handshake
//   ----------+----------------------------------------------------+--------------------------
//   request   | req_action, req_address, req_access_kind,          | taken when start & ~busy
//             | req_permanent, req_entry_index                     |
//   response  | rsp_status, rsp_hit_position, rsp_entries_used     | rsp_strobe, one cycle
//
// Sequence: exec state, then the strobe state. Add, a plain check and any request
// but purge that removes nothing go from exec straight to the strobe; the next
// request is taken after the strobe. Removals add an odd-even compaction that runs
// until the row is in order. Purge adds a full row rotation to mark entries and a
// drop state before compacting.
// Reset clears valid bits and the sequencer; busy spans exec through the strobe.
module breakpoint_match_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [bmt_pkg::ActionW-1:0]  req_action,
   input  logic [bmt_pkg::AddrW-1:0]    req_address,
   input  logic [bmt_pkg::KindW-1:0]    req_access_kind,
   input  logic                         req_permanent,
   input  logic [bmt_pkg::IndexW-1:0]   req_entry_index,
   output logic                         rsp_strobe,
   output logic [bmt_pkg::StatusW-1:0]  rsp_status,
   output logic [bmt_pkg::HitW-1:0]     rsp_hit_position,
   output logic [bmt_pkg::UsedW-1:0]    rsp_entries_used
);

   localparam int N = bmt_pkg::MaxEntries;

   bmt_pkg::entry_type   ent [N];
   logic [N:0]           seen;
   logic [N-1:0]         first_hit, left_swap, addr_hit, index_hit, key_hit, tail;
   bmt_pkg::key_type     key;
   bmt_pkg::cmd_type     cmd;
   bmt_pkg::summary_type summary;
   bmt_pkg::status_type  status;
   logic [bmt_pkg::PosW-1:0] hit_pos, rsp_pos;
   logic [bmt_pkg::CntW-1:0] used;
   logic hit_temp_raw;

   // first-hit priority ripples from slot 0 upward
   assign seen[0] = 1'b0;

   // slot i pulls from i+1 when rotating or compacting; the row wraps for rotation
   for (genvar i = 0; i < N; i++) begin : g_slot
      bmt_cell u_slot (
         .clock     (clock),
         .reset     (reset),
         .pos       (bmt_pkg::PosW'(i)),
         .cmd       (cmd),
         .key       (key),
         .probe     (ent[0]),
         .dn_in     (ent[(i + N - 1) % N]),
         .up_in     (ent[(i + 1) % N]),
         .seen_in   (seen[i]),
         .state_out (ent[i]),
         .seen_out  (seen[i+1]),
         .first_hit (first_hit[i]),
         .left_swap (left_swap[i]),
         .addr_hit  (addr_hit[i]),
         .index_hit (index_hit[i]),
         .key_hit   (key_hit[i]),
         .tail      (tail[i])
      );
   end

   // hit position and fill level; entries stay packed at the bottom between requests
   always_comb begin
      hit_pos      = '0;
      used         = '0;
      hit_temp_raw = 1'b0;
      for (int i = 0; i < N; i++) begin
         if (first_hit[i]) begin
            hit_pos      = hit_pos | bmt_pkg::PosW'(i);
            hit_temp_raw = hit_temp_raw | ~ent[i].perm;
         end
         if (tail[i]) used = used | bmt_pkg::CntW'(i + 1);
      end
   end

   always_comb begin
      summary.full     = ent[N-1].valid;
      summary.dup      = |key_hit;
      summary.hit_any  = seen[N];
      // only a temporary execute entry removes its address on a hit
      summary.hit_temp = seen[N] & hit_temp_raw & (key.kind == bmt_pkg::KIND_EXEC);
      summary.addr_any = |addr_hit;
      summary.idx_any  = |index_hit;
      summary.swap_any = |left_swap;
   end

   bmt_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_action      (req_action),
      .req_address     (req_address),
      .req_access_kind (req_access_kind),
      .req_permanent   (req_permanent),
      .req_entry_index (req_entry_index),
      .summary         (summary),
      .hit_pos         (hit_pos),
      .busy            (busy),
      .key             (key),
      .cmd             (cmd),
      .rsp_strobe      (rsp_strobe),
      .status          (status),
      .pos             (rsp_pos)
   );

   assign rsp_status       = status;
   assign rsp_hit_position = bmt_pkg::HitW'(rsp_pos);
   assign rsp_entries_used = bmt_pkg::UsedW'(used);

endmodule

@@ dv/breakpoint_match_table_test.sv @@
// Self-checking testbench of the breakpoint match table.
`timescale 1ns / 1ps

module breakpoint_match_table_test;

   typedef logic [bmt_pkg::ActionW-1:0] action_type;
   typedef logic [bmt_pkg::AddrW-1:0]   addr_type;
   typedef logic [bmt_pkg::KindW-1:0]   kind_type;
   typedef logic [bmt_pkg::IndexW-1:0]  index_type;

   // kind codes beyond execute; the package only names execute
   localparam kind_type KIND_MEM_READ  = 3'd1;
   localparam kind_type KIND_MEM_WRITE = 3'd2;
   localparam kind_type KIND_PORT_IN   = 3'd3;
   localparam kind_type KIND_PORT_OUT  = 3'd4;
   localparam kind_type KIND_TOP       = {bmt_pkg::KindW{1'b1}};

   // action codes with no defined meaning
   localparam action_type ACT_FIRST_UNUSED = bmt_pkg::ACT_PURGE + 1'b1;
   localparam action_type ACT_TOP          = {bmt_pkg::ActionW{1'b1}};

   localparam int IndexMax     = (1 << bmt_pkg::IndexW) - 1;
   localparam int DrainCycles  = bmt_pkg::MaxEntries + 8;
   // worst request: purge rotation plus full compaction, plus an idle gap
   localparam int QuietLimit   = 20 * (bmt_pkg::MaxEntries + 20);
   localparam int PrintLimit   = 50;

   typedef struct packed {
      logic     perm;
      kind_type kind;
      addr_type addr;
   } bp_entry_type;

   typedef struct packed {
      bmt_pkg::status_type           status;
      logic [bmt_pkg::HitW-1:0]      hit;
      logic [bmt_pkg::UsedW-1:0]     used;
   } bp_response_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   action_type                    req_action;
   addr_type                      req_address;
   kind_type                      req_access_kind;
   logic                          req_permanent;
   index_type                     req_entry_index;
   logic                          rsp_strobe;
   logic [bmt_pkg::StatusW-1:0]   rsp_status;
   logic [bmt_pkg::HitW-1:0]      rsp_hit_position;
   logic [bmt_pkg::UsedW-1:0]     rsp_entries_used;

   // shadow copy of the table, kept in step with every accepted request
   bp_entry_type    shadow_table [bmt_pkg::MaxEntries];
   int              shadow_count;
   bp_response_type expected_responses [$];
   int              mismatch_count;
   int              requests_issued;
   int              quiet_cycles;

   breakpoint_match_table dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_address      (req_address),
      .req_access_kind  (req_access_kind),
      .req_permanent    (req_permanent),
      .req_entry_index  (req_entry_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_hit_position (rsp_hit_position),
      .rsp_entries_used (rsp_entries_used)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Table predictor
   // ---------------------------------------------------------------------------

   // Close the gaps left by dropped entries, keeping order. Returns how many were dropped.
   function automatic int shadow_compact(input logic [bmt_pkg::MaxEntries-1:0] drop);
      int kept;
      int removed;
      kept = 0;
      for (int r = 0; r < shadow_count; r++) begin
         if (!drop[r]) begin
            shadow_table[kept] = shadow_table[r];
            kept = kept + 1;
         end
      end
      removed = shadow_count - kept;
      shadow_count = kept;
      return removed;
   endfunction

   function automatic int shadow_drop_address(input addr_type addr);
      logic [bmt_pkg::MaxEntries-1:0] drop;
      drop = '0;
      for (int i = 0; i < shadow_count; i++)
         drop[i] = (shadow_table[i].addr == addr);
      return shadow_compact(drop);
   endfunction

   // Apply one request to the shadow table and return the response it must give.
   function automatic bp_response_type predict_table_action(
      input action_type action,
      input addr_type   addr,
      input kind_type   kind,
      input logic       perm,
      input index_type  index
   );
      bp_response_type                rsp;
      logic [bmt_pkg::MaxEntries-1:0] drop;
      int                             removed;
      rsp.status = bmt_pkg::STAT_MISS;
      rsp.hit    = '0;
      drop       = '0;
      case (action)
         bmt_pkg::ACT_ADD: begin
            if (shadow_count >= bmt_pkg::MaxEntries) begin
               rsp.status = bmt_pkg::STAT_FULL;
            end else begin
               rsp.status = bmt_pkg::STAT_OK;
               for (int i = 0; i < shadow_count; i++)
                  if (shadow_table[i].addr == addr && shadow_table[i].kind == kind)
                     rsp.status = bmt_pkg::STAT_DUP;
               if (rsp.status == bmt_pkg::STAT_OK) begin
                  shadow_table[shadow_count] = '{perm: perm, kind: kind, addr: addr};
                  shadow_count = shadow_count + 1;
               end
            end
         end
         bmt_pkg::ACT_DEL_ADDR: begin
            removed = shadow_drop_address(addr);
            rsp.status = (removed != 0) ? bmt_pkg::STAT_OK : bmt_pkg::STAT_MISS;
         end
         bmt_pkg::ACT_DEL_INDEX: begin
            if (int'(index) < shadow_count) begin
               drop[index] = 1'b1;
               removed = shadow_compact(drop);
               rsp.status = bmt_pkg::STAT_OK;
            end
         end
         bmt_pkg::ACT_CHECK: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_table[i].addr == addr && shadow_table[i].kind == kind) begin
                  rsp.status = bmt_pkg::STAT_OK;
                  rsp.hit    = i[bmt_pkg::HitW-1:0];
                  // a temporary execute breakpoint is consumed, with its address
                  if (kind == bmt_pkg::KIND_EXEC && !shadow_table[i].perm)
                     removed = shadow_drop_address(addr);
                  break;
               end
            end
         end
         bmt_pkg::ACT_PURGE: begin
            // marks come from the table as it stood before the purge
            for (int i = 0; i < shadow_count; i++)
               if (!shadow_table[i].perm)
                  for (int j = 0; j < shadow_count; j++)
                     if (shadow_table[j].addr == shadow_table[i].addr)
                        drop[j] = 1'b1;
            removed = shadow_compact(drop);
            rsp.status = bmt_pkg::STAT_OK;
         end
         default: ;
      endcase
      rsp.used = shadow_count[bmt_pkg::UsedW-1:0];
      return rsp;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side: fields change on the falling edge, start held until taken
   // ---------------------------------------------------------------------------

   task automatic issue_request(
      input action_type action,
      input addr_type   addr,
      input kind_type   kind,
      input logic       perm,
      input index_type  index
   );
      @(negedge clock);
      start           <= 1'b1;
      req_action      <= action;
      req_address     <= addr;
      req_access_kind <= kind;
      req_permanent   <= perm;
      req_entry_index <= index;
      // busy read here is the value before the edge
      do @(posedge clock); while (busy);
      expected_responses.push_back(predict_table_action(action, addr, kind, perm, index));
      requests_issued = requests_issued + 1;
   endtask

   task automatic idle_cycles(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Response side: the block cannot be stalled, so every strobe is checked
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PrintLimit)
         $display("[%0t] response %s: got %0d, want %0d", $realtime, what, got, want);
      mismatch_count = mismatch_count + 1;
   endtask

   always @(posedge clock) begin
      bp_response_type want;
      if (!reset && rsp_strobe) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("with none pending, status", int'(rsp_status), 0);
         end else begin
            want = expected_responses.pop_front();
            if (rsp_status != want.status)
               report_mismatch("status", int'(rsp_status), int'(want.status));
            if (rsp_hit_position != want.hit)
               report_mismatch("hit_position", int'(rsp_hit_position), int'(want.hit));
            if (rsp_entries_used != want.used)
               report_mismatch("entries_used", int'(rsp_entries_used), int'(want.used));
         end
      end
   end

   // Run is stuck once nothing is taken or returned for too long.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((start && !busy && !reset) || rsp_strobe)
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("breakpoint_match_table: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // Mostly defined kinds, now and then the undefined ones (never execute).
   function automatic kind_type pick_kind();
      if ($urandom_range(0, 9) == 0)
         return kind_type'($urandom_range(int'(KIND_PORT_OUT) + 1, int'(KIND_TOP)));
      return kind_type'($urandom_range(int'(bmt_pkg::KIND_EXEC), int'(KIND_PORT_OUT)));
   endfunction

   // Small address pool so hits and duplicates happen, extremes and full range too.
   function automatic addr_type pick_address();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return addr_type'($urandom);
         default: return addr_type'($urandom_range(0, 15) * 32'h1111);
      endcase
   endfunction

   // Either a copy of a live entry (reuse_pct percent of the time) or a fresh one.
   function automatic bp_entry_type pick_entry(input int reuse_pct);
      bp_entry_type e;
      if (shadow_count > 0 && $urandom_range(0, 99) < reuse_pct)
         e = shadow_table[$urandom_range(0, shadow_count - 1)];
      else
         e = '{perm: 1'b0, kind: pick_kind(), addr: pick_address()};
      e.perm = 1'($urandom_range(0, 1));
      return e;
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   task automatic test_add_and_duplicate();
      issue_request(bmt_pkg::ACT_ADD, 16'h0000, bmt_pkg::KIND_EXEC, 1'b0, '0);
      issue_request(bmt_pkg::ACT_ADD, 16'hFFFF, KIND_PORT_OUT,      1'b1, '0);
      // same address+kind
      issue_request(bmt_pkg::ACT_ADD, 16'h0000, bmt_pkg::KIND_EXEC, 1'b1, '0);
      issue_request(bmt_pkg::ACT_ADD, 16'h0000, KIND_TOP,      1'b0, '0);  // undefined kind
      issue_request(bmt_pkg::ACT_ADD, 16'h1234, KIND_MEM_READ, 1'b0, '0);
   endtask

   task automatic test_check_access();
      issue_request(bmt_pkg::ACT_CHECK, 16'hFFFF, KIND_PORT_OUT,  1'b0, '1);
      // temporary but not execute: no removal
      issue_request(bmt_pkg::ACT_CHECK, 16'h0000, KIND_TOP,       1'b0, '0);
      issue_request(bmt_pkg::ACT_CHECK, 16'h1234, KIND_MEM_WRITE, 1'b0, '0);  // miss
      // temporary execute hit drops every entry at that address
      issue_request(bmt_pkg::ACT_CHECK, 16'h0000, bmt_pkg::KIND_EXEC, 1'b0, '0);
      issue_request(bmt_pkg::ACT_ADD,   16'h5555, bmt_pkg::KIND_EXEC, 1'b1, '0);
      // permanent stays
      issue_request(bmt_pkg::ACT_CHECK, 16'h5555, bmt_pkg::KIND_EXEC, 1'b0, '0);
   endtask

   task automatic test_delete();
      issue_request(bmt_pkg::ACT_ADD,       16'hAAAA, KIND_MEM_WRITE, 1'b0, '0);
      issue_request(bmt_pkg::ACT_ADD,       16'hAAAA, KIND_PORT_IN,   1'b1, '0);
      // both kinds go, then not found
      issue_request(bmt_pkg::ACT_DEL_ADDR,  16'hAAAA, bmt_pkg::KIND_EXEC, 1'b0, '0);
      issue_request(bmt_pkg::ACT_DEL_ADDR,  16'hAAAA, bmt_pkg::KIND_EXEC, 1'b0, '0);
      // beyond count, then the head
      issue_request(bmt_pkg::ACT_DEL_INDEX, 16'h0000, bmt_pkg::KIND_EXEC, 1'b0, '1);
      issue_request(bmt_pkg::ACT_DEL_INDEX, 16'h0000, bmt_pkg::KIND_EXEC, 1'b0, '0);
   endtask

   task automatic test_purge();
      issue_request(bmt_pkg::ACT_ADD,   16'h0F0F, bmt_pkg::KIND_EXEC, 1'b1, '0);
      // takes the permanent along
      issue_request(bmt_pkg::ACT_ADD,   16'h0F0F, KIND_MEM_READ, 1'b0, '0);
      issue_request(bmt_pkg::ACT_ADD,   16'h00FF, kind_type'(KIND_TOP - 1'b1), 1'b0, '0);
      issue_request(bmt_pkg::ACT_PURGE, 16'h0000, bmt_pkg::KIND_EXEC, 1'b0, '0);
      // only permanents left
      issue_request(bmt_pkg::ACT_PURGE, 16'hFFFF, KIND_TOP,      1'b1, '1);
   endtask

   task automatic test_undefined_actions();
      for (int a = int'(ACT_FIRST_UNUSED); a <= int'(ACT_TOP); a++)
         issue_request(action_type'(a), addr_type'($urandom), kind_type'($urandom),
                       1'($urandom), index_type'($urandom));
   endtask

   // Fill to capacity with random entries, then work the last slot and the head.
   task automatic test_table_full();
      bp_entry_type e;
      while (shadow_count < bmt_pkg::MaxEntries) begin
         e = pick_entry(10);
         issue_request(bmt_pkg::ACT_ADD, e.addr, e.kind, e.perm, index_type'($urandom));
         if ($urandom_range(0, 3) == 0)
            idle_cycles(int'($urandom_range(1, 16)));
      end
      e = shadow_table[0];
      issue_request(bmt_pkg::ACT_ADD, e.addr, e.kind, e.perm, '0);  // full wins over duplicate
      e = pick_entry(0);
      issue_request(bmt_pkg::ACT_ADD, e.addr, e.kind, e.perm, '0);
      e = shadow_table[bmt_pkg::MaxEntries - 1];
      issue_request(bmt_pkg::ACT_CHECK, e.addr, e.kind, e.perm, '0);  // hit on the last slot
      issue_request(bmt_pkg::ACT_DEL_INDEX, e.addr, e.kind, e.perm,
                    index_type'(bmt_pkg::MaxEntries - 1));
      // shifts the whole row
      issue_request(bmt_pkg::ACT_DEL_INDEX, e.addr, e.kind, e.perm, '0);
      issue_request(bmt_pkg::ACT_PURGE, addr_type'($urandom), kind_type'($urandom),
                    1'($urandom), index_type'($urandom));
   endtask

   // Mixed traffic; adds lean heavier while the table is sparse.
   task automatic test_random_traffic(input int items, input bit with_gaps);
      int           gap_pct;
      int           add_pct;
      int           pick;
      action_type   action;
      index_type    index;
      bp_entry_type e;
      gap_pct = 0;
      for (int i = 0; i < items; i++) begin
         if (with_gaps && (i % 32 == 0))
            gap_pct = 25 * int'($urandom_range(0, 2));
         add_pct = (shadow_count < 40) ? 45 : 20;
         pick = int'($urandom_range(0, 99));
         if (pick < add_pct)
            action = bmt_pkg::ACT_ADD;
         else if (pick < 72)
            action = bmt_pkg::ACT_CHECK;
         else if (pick < 82)
            action = bmt_pkg::ACT_DEL_ADDR;
         else if (pick < 93)
            action = bmt_pkg::ACT_DEL_INDEX;
         else if (pick < 97)
            action = bmt_pkg::ACT_PURGE;
         else
            action = action_type'($urandom_range(int'(ACT_FIRST_UNUSED), int'(ACT_TOP)));
         e = pick_entry((action == bmt_pkg::ACT_ADD) ? 25 : 70);
         if (shadow_count > 0 && $urandom_range(0, 3) != 0)
            index = index_type'($urandom_range(0, shadow_count - 1));
         else
            index = index_type'($urandom_range(0, IndexMax));
         issue_request(action, e.addr, e.kind, e.perm, index);
         if (with_gaps && $urandom_range(0, 99) < gap_pct)
            idle_cycles(int'($urandom_range(1, 16)));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_action      = bmt_pkg::ACT_ADD;
      req_address     = '0;
      req_access_kind = bmt_pkg::KIND_EXEC;
      req_permanent   = 1'b0;
      req_entry_index = '0;
      shadow_count    = 0;
      mismatch_count  = 0;
      requests_issued = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_add_and_duplicate();
      test_check_access();
      test_delete();
      test_purge();
      test_undefined_actions();
      test_table_full();
      test_random_traffic(330, 1'b1);
      // last stretch back to back
      test_random_traffic(100, 1'b0);

      @(negedge clock);
      start <= 1'b0;
      while (expected_responses.size() != 0)
         @(posedge clock);
      // catch any stray strobe after the last response
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0)
         $display("breakpoint_match_table: match");
      else
         $display("breakpoint_match_table: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/bmt_pkg.sv
hw/rtl/bmt_cell.sv
hw/rtl/bmt_ctrl.sv
hw/rtl/breakpoint_match_table.sv
dv/breakpoint_match_table_test.sv
